// ----- rtl/core/eased_movement_tween_macros.svh -----
// Assertion macros for the checker of the tween block.
`ifndef EASED_MOVEMENT_TWEEN_MACROS_SVH
`define EASED_MOVEMENT_TWEEN_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EMT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/emt_pkg.sv -----
package emt_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int POS_W = 32;
	localparam int LEN_W = 16;
	localparam int MODE_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_TWEEN_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EASING_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd3;

	localparam logic [MODE_W-1:0] MODE_EASE_IN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EASE_OUT = 2'd2;

	localparam logic ACTION_START = 1'b1;

endpackage

// ----- rtl/core/eased_movement_tween.sv -----
// Tweens a 2D signed fixed-point position toward a latched goal, one result per tick item
// taken during a move. A start item latches origin, goal and delta and gives no result.
// A tick while idle is dropped; a tick that reaches the length hands out the goal with
// tlast set, and the block is ready again once that result enters the output register.
// Otherwise a restoring divider forms t = tick / length one quotient bit per cycle, then
// a single shared multiplier squares t for the easing curve and scales the x and y deltas
// in turn. The input is not ready while an item is worked on, and a finished result waits
// in the output register until taken.
module eased_movement_tween import emt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [POS_W-1:0]     cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [2*POS_W-1:0]   s_axis_tdata,  // current_x, current_y
	input  logic                 s_axis_tuser,  // action
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [2*POS_W-1:0]   m_axis_tdata,  // new_x, new_y
	output logic                 m_axis_tlast   // finished
);

	localparam int CW = $clog2(FRAC_BITS);
	localparam int PW = POS_W + FRAC_BITS + 2;
	localparam logic [CW-1:0] DIV_LAST = CW'(0);
	localparam logic [CW-1:0] DIV_FIRST = CW'(FRAC_BITS - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_SQ   = 3'd2;
	localparam logic [2:0] S_EASE = 3'd3;
	localparam logic [2:0] S_MULX = 3'd4;
	localparam logic [2:0] S_MULY = 3'd5;
	localparam logic [2:0] S_ADDY = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0]           state_q;
	logic [LEN_W-1:0]     len_q;
	logic [MODE_W-1:0]    mode_q;
	logic [POS_W-1:0]     off_x_q, off_y_q;
	logic [LEN_W-1:0]     tick_q;
	logic                 run_q;
	logic [POS_W-1:0]     org_x_q, org_y_q, goal_x_q, goal_y_q, dlt_x_q, dlt_y_q;
	logic [CW-1:0]        cnt_q;
	logic [LEN_W-1:0]     rem_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [FRAC_BITS:0]   et_q;
	logic signed [PW-1:0] prod_q;
	logic [POS_W-1:0]     res_x_q, res_y_q;
	logic                 res_fin_q;
	logic                 out_vld_q;
	logic [2*POS_W-1:0]   out_data_q;
	logic                 out_last_q;

	logic                 in_acc;
	logic                 is_start;
	logic [LEN_W-1:0]     tick_nxt;
	logic                 tick_done;
	logic [LEN_W:0]       rem2;
	logic                 rem_ge;
	logic [POS_W-1:0]     mul_a;
	logic [FRAC_BITS:0]   mul_b;
	logic signed [PW-1:0] prod;
	logic [FRAC_BITS-1:0] sq;
	logic [FRAC_BITS:0]   et_nxt;
	logic [POS_W-1:0]     scaled;
	logic                 out_load;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign is_start = (s_axis_tuser == ACTION_START);
	assign tick_nxt = tick_q + LEN_W'(1);
	assign tick_done = (tick_nxt >= len_q);

	assign rem2 = {rem_q, 1'b0};
	assign rem_ge = (rem2 >= {1'b0, len_q});

	always_comb begin
		unique case (state_q)
			S_SQ: begin
				mul_a = {{(POS_W-FRAC_BITS){1'b0}}, quo_q};
				mul_b = {1'b0, quo_q};
			end
			S_MULX: begin
				mul_a = dlt_x_q;
				mul_b = et_q;
			end
			default: begin
				mul_a = dlt_y_q;
				mul_b = et_q;
			end
		endcase
	end

	assign prod = PW'($signed(mul_a)) * PW'($signed({1'b0, mul_b}));

	assign sq = prod_q[2*FRAC_BITS-1:FRAC_BITS];
	always_comb begin
		unique case (mode_q)
			MODE_EASE_IN:  et_nxt = {1'b0, sq};
			MODE_EASE_OUT: et_nxt = {quo_q, 1'b0} - {1'b0, sq};
			default:       et_nxt = {1'b0, quo_q};
		endcase
	end

	assign scaled = prod_q[FRAC_BITS+POS_W-1:FRAC_BITS];
	assign out_load = (state_q == S_OUT) && (!out_vld_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q <= LEN_W'(1);
			mode_q <= '0;
			off_x_q <= '0;
			off_y_q <= '0;
			tick_q <= '0;
			run_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TWEEN_LENGTH: len_q <= cfg_data[LEN_W-1:0];
					REG_EASING_MODE:  mode_q <= cfg_data[MODE_W-1:0];
					REG_OFFSET_X:     off_x_q <= cfg_data;
					REG_OFFSET_Y:     off_y_q <= cfg_data;
				endcase
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (is_start) begin
							tick_q <= '0;
							run_q <= 1'b1;
						end else if (run_q) begin
							tick_q <= tick_nxt;
							if (tick_done) begin
								run_q <= 1'b0;
								state_q <= S_OUT;
							end else begin
								state_q <= S_DIV;
							end
						end
					end
				end
				S_DIV: begin
					if (cnt_q == DIV_LAST) begin
						state_q <= S_SQ;
					end
				end
				S_SQ:   state_q <= S_EASE;
				S_EASE: state_q <= S_MULX;
				S_MULX: state_q <= S_MULY;
				S_MULY: state_q <= S_ADDY;
				S_ADDY: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && is_start) begin
					org_x_q <= s_axis_tdata[POS_W-1:0];
					org_y_q <= s_axis_tdata[2*POS_W-1:POS_W];
					goal_x_q <= s_axis_tdata[POS_W-1:0] + off_x_q;
					goal_y_q <= s_axis_tdata[2*POS_W-1:POS_W] + off_y_q;
					dlt_x_q <= off_x_q;
					dlt_y_q <= off_y_q;
				end
				rem_q <= tick_nxt;
				cnt_q <= DIV_FIRST;
				res_x_q <= goal_x_q;
				res_y_q <= goal_y_q;
				res_fin_q <= 1'b1;
			end
			S_DIV: begin
				rem_q <= rem_ge ? LEN_W'(rem2 - {1'b0, len_q}) : rem2[LEN_W-1:0];
				quo_q <= {quo_q[FRAC_BITS-2:0], rem_ge};
				cnt_q <= cnt_q - CW'(1);
			end
			S_SQ:   prod_q <= prod;
			S_EASE: et_q <= et_nxt;
			S_MULX: prod_q <= prod;
			S_MULY: begin
				prod_q <= prod;
				res_x_q <= org_x_q + scaled;
			end
			S_ADDY: begin
				res_y_q <= org_y_q + scaled;
				res_fin_q <= 1'b0;
			end
			S_OUT: begin
				if (out_load) begin
					out_data_q <= {res_y_q, res_x_q};
					out_last_q <= res_fin_q;
				end
			end
		endcase
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tlast = out_last_q;

endmodule

// ----- rtl/core/emt_checker.sv -----
`include "eased_movement_tween_macros.svh"

module emt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// A stalled result keeps its contents.
	`EMT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

	// A result never shows up in the cycle right after an item was taken.
	`EMT_ASSERT_SAME(a_out_latency, $rose(m_axis_tvalid), !$past(s_axis_tvalid && s_axis_tready), "result appeared too early")

	// A start item produces no result.
	`EMT_ASSERT_NEXT(a_start_quiet, s_axis_tvalid && s_axis_tready && s_axis_tuser, !$rose(m_axis_tvalid), "start item produced a result")

endmodule

bind eased_movement_tween emt_checker u_emt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser(s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tlast(m_axis_tlast)
);

// ----- test/eased_movement_tween_tb.sv -----
`timescale 1ns / 1ps

module eased_movement_tween_tb;
	import emt_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam logic ACTION_TICK = ~ACTION_START;
	localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 400;
	localparam int TARGET_ITEMS = 1750;

	typedef struct packed {
		logic             action;
		logic [POS_W-1:0] cur_x;
		logic [POS_W-1:0] cur_y;
	} tween_item_t;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic             fin;
	} position_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [POS_W-1:0]     cfg_data = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [2*POS_W-1:0]   s_axis_tdata = '0;  // current_x, current_y
	logic                 s_axis_tuser = 1'b0;  // action
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [2*POS_W-1:0]   m_axis_tdata;  // new_x, new_y
	logic                 m_axis_tlast;  // finished

	tween_item_t pending_items[$];
	position_t   expected_positions[$];
	tween_item_t cur_item;
	logic        drv_busy;
	int          tx_gap;
	int          rx_wait;
	logic        tx_gaps_on = 1'b0;
	logic        rx_gaps_on = 1'b0;
	logic        hold_req = 1'b0;
	logic        hold_rx = 1'b0;
	int          fail_count = 0;

	logic [LEN_W-1:0]  tween_len;
	logic [MODE_W-1:0] ease_sel;
	logic [POS_W-1:0]  offs_x, offs_y;
	logic [LEN_W-1:0]  tick_cnt;
	logic              moving;
	logic [POS_W-1:0]  org_x, org_y, goal_x, goal_y;

	eased_movement_tween u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic signed [63:0] scale_floor(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [63:0] prod;
		prod = a * b;
		return prod >>> FB;
	endfunction

	function automatic logic [POS_W-1:0] blend_axis(logic [POS_W-1:0] org,
			logic [POS_W-1:0] dst, logic signed [63:0] frac);
		logic [POS_W-1:0] diff;
		logic signed [63:0] step;
		diff = dst - org;
		step = scale_floor({{32{diff[POS_W-1]}}, diff}, frac);
		return org + step[POS_W-1:0];
	endfunction

	task automatic advance_tween(tween_item_t it);
		logic [31:0] num;
		logic signed [63:0] frac, sq;
		position_t res;
		if (it.action == ACTION_START) begin
			org_x = it.cur_x;
			org_y = it.cur_y;
			goal_x = it.cur_x + offs_x;
			goal_y = it.cur_y + offs_y;
			tick_cnt = '0;
			moving = 1'b1;
		end else if (moving) begin
			tick_cnt = tick_cnt + LEN_W'(1);
			if (tick_cnt >= tween_len) begin
				moving = 1'b0;
				res.x = goal_x;
				res.y = goal_y;
				res.fin = 1'b1;
			end else begin
				num = {16'd0, tick_cnt} << FB;
				frac = $signed({32'd0, num / {16'd0, tween_len}});
				sq = scale_floor(frac, frac);
				if (ease_sel == MODE_EASE_IN) begin
					frac = sq;
				end else if (ease_sel == MODE_EASE_OUT) begin
					frac = 2 * frac - sq;
				end
				res.x = blend_axis(org_x, goal_x, frac);
				res.y = blend_axis(org_y, goal_y, frac);
				res.fin = 1'b0;
			end
			expected_positions.push_back(res);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			drv_busy = 1'b0;
			tx_gap = 0;
			cur_item = '0;
		end else begin
			if (drv_busy && s_axis_tready) begin
				advance_tween(cur_item);
				drv_busy = 1'b0;
				tx_gap = tx_gaps_on ? $urandom_range(0, 9) : 0;
			end
			if (!drv_busy) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (pending_items.size() > 0) begin
					cur_item = pending_items.pop_front();
					drv_busy = 1'b1;
				end
			end
			s_axis_tvalid <= drv_busy;
			s_axis_tdata <= {cur_item.cur_y, cur_item.cur_x};
			s_axis_tuser <= cur_item.action;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		position_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_positions.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected item: x=%h y=%h last=%b",
							m_axis_tdata[POS_W-1:0], m_axis_tdata[2*POS_W-1:POS_W],
							m_axis_tlast);
					end
				end else begin
					want = expected_positions.pop_front();
					if (m_axis_tdata[POS_W-1:0] !== want.x ||
							m_axis_tdata[2*POS_W-1:POS_W] !== want.y ||
							m_axis_tlast !== want.fin) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch: expected x=%h y=%h last=%b, got x=%h y=%h last=%b",
								want.x, want.y, want.fin, m_axis_tdata[POS_W-1:0],
								m_axis_tdata[2*POS_W-1:POS_W], m_axis_tlast);
						end
					end
				end
				rx_wait = rx_gaps_on ? $urandom_range(0, 9) : 0;
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			m_axis_tready <= (rx_wait == 0) && !hold_rx;
		end
	end

	// The receiver stops taking results for a long stretch so that the block backs up.
	initial begin
		@(posedge hold_req);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin
		#6_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_TWEEN_LENGTH: tween_len = val[LEN_W-1:0];
			REG_EASING_MODE:  ease_sel = val[MODE_W-1:0];
			REG_OFFSET_X:     offs_x = val;
			REG_OFFSET_Y:     offs_y = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_item(logic act, logic [POS_W-1:0] x, logic [POS_W-1:0] y);
		tween_item_t it;
		it.action = act;
		it.cur_x = x;
		it.cur_y = y;
		pending_items.push_back(it);
	endtask

	task automatic settle();
		while (pending_items.size() != 0 || drv_busy || expected_positions.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [POS_W-1:0] rand_pos();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 4095) - 2048;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] rand_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return '0;
		if (r < 75) return LEN_W'($urandom_range(1, 12));
		if (r < 88) return LEN_W'($urandom_range(13, 300));
		if (r < 94) return 16'hffff;
		return LEN_W'($urandom_range(0, 65535));
	endfunction

	initial begin
		int useful, span, n, seqs;
		logic [LEN_W-1:0] len_pick;
		tween_len = 16'd1;
		ease_sel = MODE_LINEAR;
		offs_x = '0;
		offs_y = '0;
		tick_cnt = '0;
		moving = 1'b0;
		org_x = '0;
		org_y = '0;
		goal_x = '0;
		goal_y = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: an idle tick is dropped, a one-tick move lands on its origin.
		queue_item(ACTION_TICK, $urandom, $urandom);
		queue_item(ACTION_START, 32'h7fff_ffff, 32'h8000_0000);
		queue_item(ACTION_TICK, $urandom, $urandom);
		queue_item(ACTION_TICK, $urandom, $urandom);
		settle();

		// Extreme offsets of opposite sign to the origin, then left mid-move.
		write_reg(REG_TWEEN_LENGTH, 32'd4);
		write_reg(REG_EASING_MODE, POS_W'(MODE_LINEAR));
		write_reg(REG_OFFSET_X, 32'h7fff_ffff);
		write_reg(REG_OFFSET_Y, 32'h8000_0000);
		queue_item(ACTION_START, 32'h8000_0000, 32'h7fff_ffff);
		queue_item(ACTION_TICK, $urandom, $urandom);
		queue_item(ACTION_TICK, $urandom, $urandom);
		settle();

		// The offset change must not move the goal; the shorter length ends the move.
		write_reg(REG_OFFSET_X, 32'd0);
		write_reg(REG_TWEEN_LENGTH, 32'd2);
		queue_item(ACTION_TICK, $urandom, $urandom);
		queue_item(ACTION_TICK, $urandom, $urandom);
		settle();

		// Ease in, with a restart in the middle of a move.
		write_reg(REG_EASING_MODE, POS_W'(MODE_EASE_IN));
		write_reg(REG_TWEEN_LENGTH, 32'd3);
		write_reg(REG_OFFSET_X, 32'h0000_1000);
		write_reg(REG_OFFSET_Y, 32'hffff_f000);
		queue_item(ACTION_START, 32'd0, 32'd0);
		queue_item(ACTION_TICK, $urandom, $urandom);
		queue_item(ACTION_START, 32'd100, -32'sd100);
		repeat (3) queue_item(ACTION_TICK, $urandom, $urandom);
		settle();

		// Ease out with tiny offsets, where rounding toward minus infinity shows.
		write_reg(REG_EASING_MODE, POS_W'(MODE_EASE_OUT));
		write_reg(REG_TWEEN_LENGTH, 32'd5);
		write_reg(REG_OFFSET_X, 32'hffff_ffff);
		write_reg(REG_OFFSET_Y, 32'd1);
		queue_item(ACTION_START, $urandom, $urandom);
		repeat (5) queue_item(ACTION_TICK, $urandom, $urandom);
		settle();

		// Unused mode code with zero length, then the longest length.
		write_reg(REG_EASING_MODE, POS_W'(MODE_SPARE));
		write_reg(REG_TWEEN_LENGTH, 32'd0);
		queue_item(ACTION_START, $urandom, $urandom);
		queue_item(ACTION_TICK, $urandom, $urandom);
		settle();
		write_reg(REG_TWEEN_LENGTH, 32'hffff);
		write_reg(REG_OFFSET_X, 32'h7fff_ffff);
		write_reg(REG_OFFSET_Y, 32'h8000_0000);
		queue_item(ACTION_START, $urandom, $urandom);
		repeat (2) queue_item(ACTION_TICK, $urandom, $urandom);
		settle();

		// Back-pressure: results are held off while ticks keep coming.
		write_reg(REG_TWEEN_LENGTH, 32'd40);
		write_reg(REG_EASING_MODE, POS_W'(MODE_EASE_OUT));
		write_reg(REG_OFFSET_X, rand_pos());
		write_reg(REG_OFFSET_Y, rand_pos());
		hold_req <= 1'b1;
		queue_item(ACTION_START, rand_pos(), rand_pos());
		repeat (45) queue_item(ACTION_TICK, $urandom, $urandom);
		settle();

		useful = 0;
		while (useful < TARGET_ITEMS) begin
			len_pick = rand_len();
			write_reg(REG_TWEEN_LENGTH, POS_W'(len_pick));
			write_reg(REG_EASING_MODE, $urandom_range(0, 3));
			write_reg(REG_OFFSET_X, rand_pos());
			write_reg(REG_OFFSET_Y, rand_pos());
			tx_gaps_on <= ($urandom_range(0, 3) != 0);
			rx_gaps_on <= ($urandom_range(0, 3) != 0);
			seqs = $urandom_range(1, 5);
			span = (len_pick == 0) ? 1 : ((len_pick > 40) ? 40 : int'(len_pick));
			for (int s = 0; s < seqs; s++) begin
				if ($urandom_range(0, 99) < 85) begin
					queue_item(ACTION_START, rand_pos(), rand_pos());
					useful++;
					n = $urandom_range(0, span + 2);
					for (int i = 0; i < n; i++) begin
						queue_item(ACTION_TICK, $urandom, $urandom);
						if (i < span) useful++;
					end
				end else begin
					queue_item(1'($urandom_range(0, 1)), $urandom, $urandom);
				end
			end
			settle();
		end

		if (fail_count == 0 && expected_positions.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
